@@ rtl/core/sap_pkg.sv @@
// Shared types, constants and a helper function for the sweep-and-prune broad phase.
package sap_pkg;

    localparam int MAX_COLLIDERS = 8;
    localparam int COORD_WIDTH   = 16;
    localparam int NUM_EP        = 2 * MAX_COLLIDERS;
    localparam int IDX_W         = $clog2(MAX_COLLIDERS);
    localparam int CNT_W         = $clog2(MAX_COLLIDERS + 1);
    localparam int EP_W          = $clog2(NUM_EP);
    localparam int NE_W          = $clog2(NUM_EP + 1);
    localparam int CFG_W         = 4;
    localparam int OUT_IDX_W     = 3;

    // Configuration register indexes
    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_AXIS  = 1'b1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] new_collider;
        logic [OUT_IDX_W-1:0] active_collider;
        logic                 pair_valid;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             start;
    } t_ep;

    typedef struct packed {
        logic gt;
        logic overlap;
    } t_cmp;

    // Clamp a written collider count into 1..MAX_COLLIDERS
    function automatic logic [CNT_W-1:0] f_eff_count(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        begin
            if (v == '0) begin
                r = CNT_W'(1);
            end else if (32'(v) > MAX_COLLIDERS) begin
                r = CNT_W'(MAX_COLLIDERS);
            end else begin
                r = CNT_W'(v);
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/core/sweep_and_prune_broadphase.sv @@
// Top level of the sweep-and-prune broad phase: sequencer, endpoint order and active list.
//
// Boxes are loaded one word per cycle while the block sits in its load state; the collider
// index is the arrival position in the frame. The word that completes a frame starts the
// frame pass, during which the input is not ready: a stable insertion sort of the 2N kept
// endpoints, where each key is read, its value taken and compared with the endpoints before
// it, moving one of them per step; then a sweep where an end endpoint removes its box from
// the active list and a start endpoint reads its box, tests it against each active box and
// joins the list, and a final step sends the last word. All box reads share one registered
// read port of the box store and one compare unit. Results leave through an output register;
// each pair is held back until the next is found so that the final one can carry last, and
// a frame without pairs gives one marker word. Sweeping stalls only when a new pair finds
// the output register still full, and the final word waits the same way.
module sweep_and_prune_broadphase import sap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_box             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_SKEY_A = 3'd1;
    localparam logic [2:0] S_SKEY_B = 3'd2;
    localparam logic [2:0] S_SCMP   = 3'd3;
    localparam logic [2:0] S_WFETCH = 3'd4;
    localparam logic [2:0] S_WCBOX  = 3'd5;
    localparam logic [2:0] S_TEST   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_n;
    logic [1:0]       r_axis;
    logic [CNT_W-1:0] r_load;
    logic [NE_W-1:0]  r_i;
    logic [NE_W-1:0]  r_j;
    t_ep              r_key;
    t_coord           r_kv;
    logic [IDX_W-1:0] r_c;
    t_box             r_cbox;
    logic [IDX_W-1:0] r_k;
    logic [CNT_W-1:0] r_cnt;
    t_ep              r_order [NUM_EP];
    logic [IDX_W-1:0] r_list  [MAX_COLLIDERS];
    logic [IDX_W-1:0] r_pos   [MAX_COLLIDERS];
    logic             r_pend_v;
    logic [IDX_W-1:0] r_pend_new;
    logic [IDX_W-1:0] r_pend_act;
    logic             r_out_valid;
    t_out             r_out;

    logic [NE_W-1:0]  w_ne;
    logic [EP_W-1:0]  w_i;
    logic [EP_W-1:0]  w_jm1;
    logic [EP_W-1:0]  w_jm2;
    logic [IDX_W-1:0] w_raddr;
    logic             w_start_sel;
    t_box             w_q;
    t_coord           w_val;
    t_cmp             w_cmp;
    logic             w_out_free;
    logic             w_load_we;
    logic [CNT_W-1:0] w_new_n;
    t_ep              w_fe;
    logic [IDX_W-1:0] w_rpos;
    logic [IDX_W-1:0] w_lastc;
    logic             w_stall;

    assign w_ne       = NE_W'({r_n, 1'b0});
    assign w_i        = r_i[EP_W-1:0];
    assign w_jm1      = EP_W'(r_j - NE_W'(1));
    assign w_jm2      = EP_W'(r_j - NE_W'(2));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load_we  = (r_state == S_LOAD) && i_in_valid;
    assign w_new_n    = f_eff_count(i_cfg_data);
    assign w_fe       = r_order[w_i];
    assign w_rpos     = r_pos[w_fe.idx];
    assign w_lastc    = r_list[IDX_W'(r_cnt - CNT_W'(1))];
    assign w_stall    = w_cmp.overlap && r_pend_v && !w_out_free;

    // select the box store read address for the next step
    always_comb begin
        w_start_sel = 1'b0;
        unique case (r_state)
            S_SKEY_A: w_raddr = r_order[w_i].idx;
            S_SKEY_B: begin
                w_raddr     = r_order[w_jm1].idx;
                w_start_sel = r_key.start;
            end
            S_SCMP: begin
                w_raddr     = r_order[w_jm2].idx;
                w_start_sel = r_order[w_jm1].start;
            end
            S_WFETCH: w_raddr = w_fe.idx;
            S_WCBOX:  w_raddr = r_list[0];
            S_TEST:   w_raddr = w_stall ? r_list[r_k] : r_list[IDX_W'(r_k + IDX_W'(1))];
            default:  w_raddr = '0;
        endcase
    end

    sap_box_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (r_load[IDX_W-1:0]),
        .i_wdata (i_in_data),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    sap_cmp u_cmp (
        .i_box   (w_q),
        .i_cbox  (r_cbox),
        .i_axis  (r_axis),
        .i_start (w_start_sel),
        .i_kv    (r_kv),
        .o_val   (w_val),
        .o_res   (w_cmp)
    );

    // sequencer, endpoint order, active list and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= CNT_W'(1);
            r_axis      <= AXIS_X;
            r_load      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < MAX_COLLIDERS; e++) begin
                r_order[2*e]   <= '{idx: IDX_W'(e), start: 1'b1};
                r_order[2*e+1] <= '{idx: IDX_W'(e), start: 1'b0};
            end
        end else begin
            // drop a taken word
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // configuration writes; a count change restarts the frame
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_COUNT) begin
                    r_n <= w_new_n;
                    if (w_new_n != r_n) begin
                        r_load <= '0;
                        for (int e = 0; e < MAX_COLLIDERS; e++) begin
                            r_order[2*e]   <= '{idx: IDX_W'(e), start: 1'b1};
                            r_order[2*e+1] <= '{idx: IDX_W'(e), start: 1'b0};
                        end
                    end
                end else begin
                    r_axis <= i_cfg_data[1:0];
                end
            end

            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (r_load + CNT_W'(1) >= r_n) begin
                            r_load  <= '0;
                            r_i     <= NE_W'(1);
                            r_state <= S_SKEY_A;
                        end else begin
                            r_load <= r_load + CNT_W'(1);
                        end
                    end
                end
                S_SKEY_A: begin
                    r_key   <= r_order[w_i];
                    r_j     <= r_i;
                    r_state <= S_SKEY_B;
                end
                S_SKEY_B: begin
                    r_kv    <= w_val;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (w_cmp.gt) begin
                        r_order[r_j[EP_W-1:0]] <= r_order[w_jm1];
                        r_j <= r_j - NE_W'(1);
                    end else begin
                        r_order[r_j[EP_W-1:0]] <= r_key;
                    end
                    // advance to the next key once the slot is found
                    if (!w_cmp.gt || r_j == NE_W'(1)) begin
                        if (w_cmp.gt) begin
                            r_order[0] <= r_key;
                        end
                        if (r_i + NE_W'(1) >= w_ne) begin
                            r_i     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_WFETCH;
                        end else begin
                            r_i     <= r_i + NE_W'(1);
                            r_state <= S_SKEY_A;
                        end
                    end
                end
                S_WFETCH: begin
                    if (w_fe.start) begin
                        r_c     <= w_fe.idx;
                        r_state <= S_WCBOX;
                    end else begin
                        // swap-remove an active collider
                        if (r_cnt != '0 && CNT_W'(w_rpos) < r_cnt &&
                            r_list[w_rpos] == w_fe.idx) begin
                            r_pos[w_lastc]  <= w_rpos;
                            r_list[w_rpos]  <= w_lastc;
                            r_cnt           <= r_cnt - CNT_W'(1);
                        end
                        if (r_i + NE_W'(1) >= w_ne) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i <= r_i + NE_W'(1);
                        end
                    end
                end
                S_WCBOX: begin
                    r_cbox <= w_q;
                    r_k    <= '0;
                    if (r_cnt == '0) begin
                        r_pos[r_c]                <= '0;
                        r_list[0]                 <= r_c;
                        r_cnt                     <= CNT_W'(1);
                        if (r_i + NE_W'(1) >= w_ne) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + NE_W'(1);
                            r_state <= S_WFETCH;
                        end
                    end else begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (!w_stall) begin
                        // hold the newest pair back, pass the older one on
                        if (w_cmp.overlap) begin
                            if (r_pend_v) begin
                                r_out_valid <= 1'b1;
                                r_out <= '{new_collider: OUT_IDX_W'(r_pend_new),
                                           active_collider: OUT_IDX_W'(r_pend_act),
                                           pair_valid: 1'b1, last: 1'b0};
                            end
                            r_pend_v   <= 1'b1;
                            r_pend_new <= r_c;
                            r_pend_act <= r_list[r_k];
                        end
                        if (CNT_W'(r_k) + CNT_W'(1) >= r_cnt) begin
                            r_pos[r_c]                  <= IDX_W'(r_cnt);
                            r_list[IDX_W'(r_cnt)]       <= r_c;
                            r_cnt                       <= r_cnt + CNT_W'(1);
                            if (r_i + NE_W'(1) >= w_ne) begin
                                r_state <= S_FIN;
                            end else begin
                                r_i     <= r_i + NE_W'(1);
                                r_state <= S_WFETCH;
                            end
                        end else begin
                            r_k <= r_k + IDX_W'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_pend_v) begin
                            r_out <= '{new_collider: OUT_IDX_W'(r_pend_new),
                                       active_collider: OUT_IDX_W'(r_pend_act),
                                       pair_valid: 1'b1, last: 1'b1};
                        end else begin
                            r_out <= '{new_collider: '0, active_collider: '0,
                                       pair_valid: 1'b0, last: 1'b1};
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/sap_box_mem.sv @@
// Box store: one write port, one read port with registered read data.
module sap_box_mem import sap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_box             i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_box             o_rdata
);

    t_box r_mem [MAX_COLLIDERS];
    t_box r_q;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/core/sap_cmp.sv @@
// Shared compare unit: endpoint value pick, sort compare and three-axis overlap test.
module sap_cmp import sap_pkg::*; (
    input  t_box       i_box,
    input  t_box       i_cbox,
    input  logic [1:0] i_axis,
    input  logic       i_start,
    input  t_coord     i_kv,
    output t_coord     o_val,
    output t_cmp       o_res
);

    t_coord w_val;

    // pick the endpoint value on the sort axis; the unused code acts as z
    always_comb begin
        case (i_axis)
            AXIS_X:  w_val = i_start ? i_box.min_x : i_box.max_x;
            AXIS_Y:  w_val = i_start ? i_box.min_y : i_box.max_y;
            default: w_val = i_start ? i_box.min_z : i_box.max_z;
        endcase
    end

    assign o_val    = w_val;
    assign o_res.gt = (w_val > i_kv);

    // inclusive overlap of the held box against the read box
    assign o_res.overlap = !(i_cbox.min_x > i_box.max_x) && !(i_cbox.max_x < i_box.min_x) &&
                           !(i_cbox.min_y > i_box.max_y) && !(i_cbox.max_y < i_box.min_y) &&
                           !(i_cbox.min_z > i_box.max_z) && !(i_cbox.max_z < i_box.min_z);

endmodule

@@ sim/sweep_and_prune_broadphase_tb.sv @@
// Testbench for the sweep-and-prune broad phase: directed table, random frames, pair prediction.
module sweep_and_prune_broadphase_tb import sap_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 200;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_box             i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;

    sweep_and_prune_broadphase u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state
    t_box             pred_boxes [MAX_COLLIDERS];
    t_ep              pred_order [NUM_EP];
    int               pred_loaded;
    logic [CFG_W-1:0] pred_count_reg;
    logic [1:0]       pred_axis;

    t_out expected_pairs [$];
    int   fail_count;
    int   pair_words;
    int   frame_words;
    int   words_sent;
    int   cycle_count;
    bit   stim_done;

    // Directed stimulus: register writes, boxes and typed-in expectations
    typedef enum logic [1:0] {ROW_CFG, ROW_BOX, ROW_BOX_EXP} t_row_kind;
    typedef struct {
        t_row_kind        kind;
        logic             reg_idx;
        logic [CFG_W-1:0] reg_val;
        t_box             box;
        t_out             exp_word;
    } t_row;
    t_row stim_table [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic int eff_colliders(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_COLLIDERS) return MAX_COLLIDERS;
        return int'(v);
    endfunction

    function automatic void restore_order();
        for (int i = 0; i < MAX_COLLIDERS; i++) begin
            pred_order[2*i]       = '{idx: IDX_W'(i), start: 1'b1};
            pred_order[2*i+1]     = '{idx: IDX_W'(i), start: 1'b0};
        end
    endfunction

    function automatic t_coord endpoint_coord(t_ep e);
        t_box b;
        b = pred_boxes[e.idx];
        case (pred_axis)
            AXIS_X:  return e.start ? b.min_x : b.max_x;
            AXIS_Y:  return e.start ? b.min_y : b.max_y;
            default: return e.start ? b.min_z : b.max_z;
        endcase
    endfunction

    function automatic bit boxes_touch(int a, int b);
        t_box p, q;
        p = pred_boxes[a];
        q = pred_boxes[b];
        return !(p.min_x > q.max_x || p.max_x < q.min_x ||
                 p.min_y > q.max_y || p.max_y < q.min_y ||
                 p.min_z > q.max_z || p.max_z < q.min_z);
    endfunction

    function automatic void apply_register(logic idx, logic [CFG_W-1:0] val);
        int prev;
        prev = eff_colliders(pred_count_reg);
        if (idx == REG_COUNT) begin
            pred_count_reg = val;
            if (eff_colliders(val) != prev) begin
                restore_order();
                pred_loaded = 0;
            end
        end else begin
            pred_axis = val[1:0];
        end
    endfunction

    // Load one box; on frame completion sort, sweep and queue the pairs
    function automatic void load_box(t_box b);
        int   n, j, cnt, found, pos;
        t_ep  key, e;
        int   actives [MAX_COLLIDERS];
        int   act_pos [MAX_COLLIDERS];
        int   nact;
        t_out w;
        n = eff_colliders(pred_count_reg);
        if (pred_loaded >= n) pred_loaded = 0;
        pred_boxes[pred_loaded] = b;
        pred_loaded++;
        if (pred_loaded < n) return;
        pred_loaded = 0;
        frame_words++;
        for (int i = 1; i < 2*n; i++) begin
            key = pred_order[i];
            j = i;
            while (j > 0 && endpoint_coord(pred_order[j-1]) > endpoint_coord(key)) begin
                pred_order[j] = pred_order[j-1];
                j--;
            end
            pred_order[j] = key;
        end
        nact = 0;
        found = 0;
        for (int i = 0; i < MAX_COLLIDERS; i++) act_pos[i] = 0;
        for (int i = 0; i < 2*n; i++) begin
            e = pred_order[i];
            if (e.start) begin
                for (int k = 0; k < nact; k++) begin
                    if (boxes_touch(e.idx, actives[k])) begin
                        w.new_collider    = e.idx;
                        w.active_collider = OUT_IDX_W'(actives[k]);
                        w.pair_valid      = 1'b1;
                        w.last            = 1'b0;
                        expected_pairs.push_back(w);
                        found++;
                    end
                end
                act_pos[e.idx] = nact;
                actives[nact] = e.idx;
                nact++;
            end else begin
                pos = act_pos[e.idx];
                if (nact > 0 && pos < nact && actives[pos] == e.idx) begin
                    cnt = actives[nact-1];
                    act_pos[cnt] = pos;
                    actives[pos] = cnt;
                    nact--;
                end
            end
        end
        if (found == 0) begin
            w = '{new_collider: '0, active_collider: '0, pair_valid: 1'b0, last: 1'b1};
            expected_pairs.push_back(w);
        end else begin
            expected_pairs[$].last = 1'b1;
        end
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Mostly well-formed boxes in a small region so that pairs are common
    function automatic t_box rand_box();
        t_box   b;
        t_coord lo [3];
        t_coord hi [3];
        int     centre;
        centre = $urandom_range(0, 3) == 0 ? 0 : 0;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                lo[k] = rand_coord();
                hi[k] = rand_coord();
            end else begin
                lo[k] = t_coord'($signed(centre + $urandom_range(0, 400)) - 200);
                hi[k] = t_coord'(lo[k] + $urandom_range(0, 150));
            end
        end
        b = '{min_x: lo[0], min_y: lo[1], min_z: lo[2],
              max_x: hi[0], max_y: hi[1], max_z: hi[2]};
        return b;
    endfunction

    // Idle cycles before the next box: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one box; valid is left high until the next box or a drop replaces it
    task automatic send_box(t_box b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        load_box(b);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_pairs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_register(idx, val);
    endtask

    // Receiver with random stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < 8) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected result word %p", o_out_data);
                fail_count++;
            end else begin
                want = expected_pairs.pop_front();
                pair_words++;
                if (o_out_data.new_collider !== want.new_collider) begin
                    $error("new_collider: expected %0d, got %0d",
                           want.new_collider, o_out_data.new_collider);
                    fail_count++;
                end
                if (o_out_data.active_collider !== want.active_collider) begin
                    $error("active_collider: expected %0d, got %0d",
                           want.active_collider, o_out_data.active_collider);
                    fail_count++;
                end
                if (o_out_data.pair_valid !== want.pair_valid) begin
                    $error("pair_valid: expected %0b, got %0b",
                           want.pair_valid, o_out_data.pair_valid);
                    fail_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out_data.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_box mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
        t_box b;
        b = '{min_x: t_coord'(x0), min_y: t_coord'(y0), min_z: t_coord'(z0),
              max_x: t_coord'(x1), max_y: t_coord'(y1), max_z: t_coord'(z1)};
        return b;
    endfunction

    function automatic void add_cfg(logic idx, logic [CFG_W-1:0] val);
        t_row r;
        r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, box: '0, exp_word: '0};
        stim_table.push_back(r);
    endfunction

    function automatic void add_box(t_box b, bit typed, t_out w);
        t_row r;
        r = '{kind: typed ? ROW_BOX_EXP : ROW_BOX, reg_idx: 1'b0, reg_val: '0,
              box: b, exp_word: w};
        stim_table.push_back(r);
    endfunction

    function automatic void build_table();
        t_out marker, none;
        marker = '{new_collider: '0, active_collider: '0, pair_valid: 1'b0, last: 1'b1};
        none   = '0;
        // Single collider after reset: always an empty-frame marker
        add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1, marker);
        add_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768), 1, marker);
        // Count zero acts as one
        add_cfg(REG_COUNT, 4'd0);
        add_box(mk_box(0, 0, 0, 0, 0, 0), 1, marker);
        // Two touching boxes, then two apart, sorted on x
        add_cfg(REG_COUNT, 4'd2);
        add_box(mk_box(0, 0, 0, 10, 10, 10), 0, none);
        add_box(mk_box(10, 10, 10, 20, 20, 20), 0, none);
        add_box(mk_box(0, 0, 0, 10, 10, 10), 0, none);
        add_box(mk_box(11, 0, 0, 20, 10, 10), 1, marker);
        add_cfg(REG_AXIS, 4'd1);
        add_box(mk_box(5, 5, 5, -5, -5, -5), 0, none);
        add_box(mk_box(0, 0, 0, 1, 1, 1), 0, none);
        add_cfg(REG_AXIS, 4'd2);
        // Same effective count: order kept, frame unchanged
        add_cfg(REG_COUNT, 4'd2);
        add_box(mk_box(0, 0, 0, 100, 100, 100), 0, none);
        add_box(mk_box(50, 50, 50, 60, 60, 60), 0, none);
        // Count above range, unused axis code
        add_cfg(REG_AXIS, 4'd3);
        add_cfg(REG_COUNT, 4'd15);
        for (int i = 0; i < 8; i++)
            add_box(mk_box(i*4, 0, -i, i*4+6, 8, 32767), 0, none);
        add_cfg(REG_AXIS, 4'd0);
    endfunction

    initial begin
        t_row r;
        int   n;
        fail_count = 0; pair_words = 0; frame_words = 0; words_sent = 0;
        cycle_count = 0; stim_done = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = 1'b0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_data = '0;
        pred_count_reg = 4'd1; pred_axis = 2'd0; pred_loaded = 0;
        restore_order();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        build_table();
        foreach (stim_table[i]) begin
            r = stim_table[i];
            if (r.kind == ROW_CFG) begin
                write_register(r.reg_idx, r.reg_val);
            end else begin
                send_box(r.box);
                if (r.kind == ROW_BOX_EXP && expected_pairs.size() != 0
                    && expected_pairs[$] != r.exp_word) begin
                    $error("table row %0d: expected %p, predicted %p",
                           i, r.exp_word, expected_pairs[$]);
                    fail_count++;
                end
            end
        end

        // Random frames over several settings, extremes included
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0:       n = 8;
                1:       n = 1;
                2:       n = 0;
                3:       n = 12;
                default: n = $urandom_range(2, 8);
            endcase
            write_register(REG_AXIS, CFG_W'($urandom_range(0, 3)));
            write_register(REG_COUNT, CFG_W'(n));
            repeat (3 * eff_colliders(CFG_W'(n)) + $urandom_range(0, 2))
                send_box(rand_box());
        end
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    // End of run and timeout
    initial begin
        wait (i_rst_n === 1'b1);
        while (!(stim_done && expected_pairs.size() == 0) && cycle_count < CYCLE_LIMIT)
            @(negedge i_clk);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            $display("Sent %0d boxes, completed %0d frames, checked %0d result words.",
                     words_sent, frame_words, pair_words);
            if (fail_count == 0 && expected_pairs.size() == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
            $finish;
        end
    end

endmodule
